### rtl/core/tile_map_scroll_edge_redraw_unit_assert.svh
// assertion helpers used by tmser_back
// both expect clk and rst_n in scope
`ifndef TILE_MAP_SCROLL_EDGE_REDRAW_UNIT_ASSERT_SVH
`define TILE_MAP_SCROLL_EDGE_REDRAW_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define TMSER_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmser same-cycle check failed");

// condition holds in the following cycle
`define TMSER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmser next-cycle check failed");

`endif

### rtl/core/tmser_pkg.sv
package tmser_pkg;

    localparam int MAP_W        = 64;
    localparam int MAP_H        = 64;
    localparam int TILE_PIX     = 16;
    localparam int TILE_SHIFT   = 4;
    localparam int SCREEN_W_PIX = 320;
    localparam int SCREEN_H_PIX = 240;
    localparam int MAP_W_PIX    = MAP_W * TILE_PIX;
    localparam int MAP_H_PIX    = MAP_H * TILE_PIX;
    localparam int ROW_LEN      = 1 + SCREEN_W_PIX / TILE_PIX;
    localparam int COL_LEN      = 1 + SCREEN_H_PIX / TILE_PIX;
    localparam int MAP_DEPTH    = MAP_W * MAP_H;

    localparam int ORIGIN_X_RESET = 160;
    localparam int ORIGIN_Y_RESET = 200;

    localparam int ORG_W  = 10;
    localparam int SUM_W  = 11;
    localparam int TILE_W = 8;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int SX_W   = 10;
    localparam int SY_W   = 9;
    localparam int IDX_W  = 5;
    localparam int ADDR_W = ROW_W + COL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SCROLL = 1'b1;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_COL   = 2'd1;
    localparam logic [1:0] CMD_ROW   = 2'd2;
    localparam logic [1:0] CMD_BLOCK = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [ROW_W-1:0]        trow;
        logic [COL_W-1:0]        tcol;
        logic signed [SX_W-1:0]  sx0;
        logic signed [SY_W-1:0]  sy0;
        logic [ORG_W-1:0]        view_x;
        logic [ORG_W-1:0]        view_y;
        logic [TILE_W-1:0]       tile;
    } cmd_t;

endpackage

### rtl/core/tmser_queue.sv
module tmser_queue
    import tmser_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic head_valid,
    output cmd_t head_data,
    input  logic pop
);

    cmd_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/tmser_front.sv
module tmser_front
    import tmser_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               op,
    input  logic [1:0]         dir,
    input  logic [3:0]         step,
    input  logic [ROW_W-1:0]   map_row,
    input  logic [COL_W-1:0]   map_col,
    input  logic [TILE_W-1:0]  tile_in,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_data
);

    logic [ORG_W-1:0] ox_reg, ox_next;
    logic [ORG_W-1:0] oy_reg, oy_next;
    logic             accept;
    logic [ORG_W-1:0] step_ext;
    logic             left_ok, right_ok, up_ok, down_ok;
    logic [ORG_W-1:0] nx_left, nx_right, ny_up, ny_down;
    logic [SUM_W-1:0] edge_r, edge_d;
    logic [COL_W-1:0] tcol_left, tcol_right;
    logic [ROW_W-1:0] trow_up, trow_down;
    logic [ROW_W-1:0] trow_cur;
    logic [COL_W-1:0] tcol_cur;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign q_push    = accept;
    assign step_ext  = ORG_W'(step);

    // bound tests, same form as the map limits
    assign left_ok  = ox_reg > step_ext;
    assign up_ok    = oy_reg > step_ext;
    assign right_ok = (SUM_W'(ox_reg) + SUM_W'(SCREEN_W_PIX) + SUM_W'(step))
                      < SUM_W'(MAP_W_PIX);
    assign down_ok  = (SUM_W'(oy_reg) + SUM_W'(SCREEN_H_PIX) + SUM_W'(step))
                      < SUM_W'(MAP_H_PIX);

    assign nx_left  = ox_reg - step_ext;
    assign nx_right = ox_reg + step_ext;
    assign ny_up    = oy_reg - step_ext;
    assign ny_down  = oy_reg + step_ext;

    assign edge_r = SUM_W'(nx_right) + SUM_W'(SCREEN_W_PIX - 1);
    assign edge_d = SUM_W'(ny_down) + SUM_W'(SCREEN_H_PIX - 1);

    assign tcol_left  = nx_left[TILE_SHIFT +: COL_W];
    assign tcol_right = edge_r[TILE_SHIFT +: COL_W];
    assign trow_up    = ny_up[TILE_SHIFT +: ROW_W];
    assign trow_down  = edge_d[TILE_SHIFT +: ROW_W];
    assign trow_cur   = oy_reg[TILE_SHIFT +: ROW_W];
    assign tcol_cur   = ox_reg[TILE_SHIFT +: COL_W];

    always_comb
    begin
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        q_data         = '0;
        q_data.view_x  = ox_reg;
        q_data.view_y  = oy_reg;
        if (op == OP_WRITE)
        begin
            q_data.kind = CMD_WRITE;
            q_data.trow = map_row;
            q_data.tcol = map_col;
            q_data.tile = tile_in;
        end
        else
        begin
            q_data.kind = CMD_BLOCK;
            case (dir)
                DIR_LEFT:
                begin
                    if (left_ok)
                    begin
                        ox_next        = nx_left;
                        q_data.kind    = CMD_COL;
                        q_data.view_x  = nx_left;
                        q_data.tcol    = tcol_left;
                        q_data.trow    = trow_cur;
                        q_data.sx0     = SX_W'({tcol_left, TILE_SHIFT'(0)}) - SX_W'(nx_left);
                        q_data.sy0     = SY_W'({trow_cur, TILE_SHIFT'(0)}) - SY_W'(oy_reg);
                    end
                end
                DIR_RIGHT:
                begin
                    if (right_ok)
                    begin
                        ox_next        = nx_right;
                        q_data.kind    = CMD_COL;
                        q_data.view_x  = nx_right;
                        q_data.tcol    = tcol_right;
                        q_data.trow    = trow_cur;
                        q_data.sx0     = SX_W'({tcol_right, TILE_SHIFT'(0)}) - SX_W'(nx_right);
                        q_data.sy0     = SY_W'({trow_cur, TILE_SHIFT'(0)}) - SY_W'(oy_reg);
                    end
                end
                DIR_UP:
                begin
                    if (up_ok)
                    begin
                        oy_next        = ny_up;
                        q_data.kind    = CMD_ROW;
                        q_data.view_y  = ny_up;
                        q_data.trow    = trow_up;
                        q_data.tcol    = tcol_cur;
                        q_data.sx0     = SX_W'({tcol_cur, TILE_SHIFT'(0)}) - SX_W'(ox_reg);
                        q_data.sy0     = SY_W'({trow_up, TILE_SHIFT'(0)}) - SY_W'(ny_up);
                    end
                end
                default:
                begin
                    if (down_ok)
                    begin
                        oy_next        = ny_down;
                        q_data.kind    = CMD_ROW;
                        q_data.view_y  = ny_down;
                        q_data.trow    = trow_down;
                        q_data.tcol    = tcol_cur;
                        q_data.sx0     = SX_W'({tcol_cur, TILE_SHIFT'(0)}) - SX_W'(ox_reg);
                        q_data.sy0     = SY_W'({trow_down, TILE_SHIFT'(0)}) - SY_W'(ny_down);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg <= ORG_W'(ORIGIN_X_RESET);
            oy_reg <= ORG_W'(ORIGIN_Y_RESET);
        end
        else if (accept)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

endmodule

### rtl/core/tmser_back.sv
module tmser_back
    import tmser_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cmd_t                   q_data,
    output logic                   q_pop,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [TILE_W-1:0]      tile_out,
    output logic signed [SX_W-1:0] screen_x,
    output logic signed [SY_W-1:0] screen_y,
    output logic                   moved,
    output logic [ORG_W-1:0]       view_x,
    output logic [ORG_W-1:0]       view_y,
    output logic                   last
);

    `include "tile_map_scroll_edge_redraw_unit_assert.svh"

    logic [TILE_W-1:0]       map_mem [MAP_DEPTH];
    logic [TILE_W-1:0]       rd_data_reg;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        len;
    logic [ROW_W-1:0]        el_row;
    logic [COL_W-1:0]        el_col;
    logic signed [SX_W-1:0]  el_sx;
    logic signed [SY_W-1:0]  el_sy;
    logic                    el_last;
    logic                    do_write, do_issue, rd_en, can_issue, s1_adv;

    logic                    s1_valid_reg;
    logic                    s1_blank_reg;
    logic signed [SX_W-1:0]  s1_sx_reg;
    logic signed [SY_W-1:0]  s1_sy_reg;
    logic [ORG_W-1:0]        s1_vx_reg, s1_vy_reg;
    logic                    s1_last_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [TILE_W-1:0]       out_tile_reg;
    logic signed [SX_W-1:0]  out_sx_reg;
    logic signed [SY_W-1:0]  out_sy_reg;
    logic                    out_moved_reg;
    logic [ORG_W-1:0]        out_vx_reg, out_vy_reg;
    logic                    out_last_reg;

    assign len = (q_data.kind == CMD_ROW) ? IDX_W'(ROW_LEN) : IDX_W'(COL_LEN);

    // step along the edge: rows for a column, columns for a row
    always_comb
    begin
        el_row = q_data.trow;
        el_col = q_data.tcol;
        el_sx  = q_data.sx0;
        el_sy  = q_data.sy0;
        case (q_data.kind)
            CMD_COL:
            begin
                el_row = q_data.trow + ROW_W'(idx_reg);
                el_sy  = q_data.sy0 + (SY_W'(idx_reg) << TILE_SHIFT);
            end
            CMD_ROW:
            begin
                el_col = q_data.tcol + COL_W'(idx_reg);
                el_sx  = q_data.sx0 + (SX_W'(idx_reg) << TILE_SHIFT);
            end
            default:
            begin
                el_row = q_data.trow;
            end
        endcase
    end

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign can_issue = !s1_valid_reg || s1_adv;
    assign do_write  = q_valid && (q_data.kind == CMD_WRITE);
    assign do_issue  = q_valid && (q_data.kind != CMD_WRITE) && can_issue;
    assign rd_en     = do_issue && (q_data.kind != CMD_BLOCK);
    assign el_last   = (q_data.kind == CMD_BLOCK) || (idx_reg == len - 1'b1);
    assign q_pop     = do_write || (do_issue && el_last);

    always_comb
    begin
        idx_next = idx_reg;
        if (do_issue)
        begin
            idx_next = el_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // tile map, one write or one read a cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            map_mem[{q_data.trow, q_data.tcol}] <= q_data.tile;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[{el_row, el_col}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= do_issue || (s1_valid_reg && !s1_adv);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_issue)
        begin
            s1_blank_reg <= (q_data.kind == CMD_BLOCK);
            s1_sx_reg    <= el_sx;
            s1_sy_reg    <= el_sy;
            s1_vx_reg    <= q_data.view_x;
            s1_vy_reg    <= q_data.view_y;
            s1_last_reg  <= el_last;
        end
        if (s1_adv)
        begin
            out_tile_reg  <= s1_blank_reg ? '0 : rd_data_reg;
            out_sx_reg    <= s1_sx_reg;
            out_sy_reg    <= s1_sy_reg;
            out_moved_reg <= !s1_blank_reg;
            out_vx_reg    <= s1_vx_reg;
            out_vy_reg    <= s1_vy_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign tile_out  = out_tile_reg;
    assign screen_x  = out_sx_reg;
    assign screen_y  = out_sy_reg;
    assign moved     = out_moved_reg;
    assign view_x    = out_vx_reg;
    assign view_y    = out_vy_reg;
    assign last      = out_last_reg;

    `TMSER_ASSERT_SAME(a_blocked_word, rsp_valid && !moved, last && (tile_out == '0))
    `TMSER_ASSERT_NEXT(a_stage_to_output, s1_adv, out_valid_reg)
    `TMSER_ASSERT_SAME(a_idx_in_range, q_valid && (q_data.kind == CMD_COL), idx_reg < IDX_W'(COL_LEN))
    `TMSER_ASSERT_SAME(a_no_write_on_read, do_write, !rd_en)

endmodule

### rtl/core/tile_map_scroll_edge_redraw_unit.sv
// an accepted scroll passes the queue, the stage-1 and map read registers, then the output register
// a scroll that moves reads one tile per cycle while the output is not stalled: 16 tiles for a column, 21 for a row
// a blocked scroll yields one blank result word and a map write yields none; the single map port sets the pace
// the front end takes a new word while fewer than two commands wait in the queue
// reset: origin goes to (160, 200), queue and output empty; map contents undefined until written
module tile_map_scroll_edge_redraw_unit
    import tmser_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic                   op,
    input  logic [1:0]             dir,
    input  logic [3:0]             step,
    input  logic [ROW_W-1:0]       map_row,
    input  logic [COL_W-1:0]       map_col,
    input  logic [TILE_W-1:0]      tile_in,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [TILE_W-1:0]      tile_out,
    output logic signed [SX_W-1:0] screen_x,
    output logic signed [SY_W-1:0] screen_y,
    output logic                   moved,
    output logic [ORG_W-1:0]       view_x,
    output logic [ORG_W-1:0]       view_y,
    output logic                   last
);

    logic q_full, q_push, q_valid, q_pop;
    cmd_t q_in, q_head;

    tmser_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .dir       (dir),
        .step      (step),
        .map_row   (map_row),
        .map_col   (map_col),
        .tile_in   (tile_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tmser_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop)
    );

    tmser_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .tile_out  (tile_out),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .moved     (moved),
        .view_x    (view_x),
        .view_y    (view_y),
        .last      (last)
    );

endmodule
